>>> hdl/wmf_pkg.sv
// Package: constants, types and helper functions of the window median filter.
package wmf_pkg;

    localparam int MAX_LINE_DEF   = 2048;
    localparam int MAX_HALF_DEF   = 3;
    localparam int PIXEL_BITS_DEF = 16;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int LEN_BITS      = 12;
    localparam int CNT_BITS      = 16;
    localparam int HALF_BITS     = 2;
    localparam int MED_BITS      = 16;
    localparam int POSX_BITS     = 11;
    localparam int POSY_BITS     = 16;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_LINE_LENGTH = 2'd0,
        REG_LINE_COUNT  = 2'd1,
        REG_HALF_X      = 2'd2,
        REG_HALF_Y      = 2'd3
    } t_cfg_reg;

    // Sort engine states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_LOAD = 2'd1,
        ST_SORT = 2'd2,
        ST_DONE = 2'd3
    } t_state;

    // Result bookkeeping handed from the front end to the sorter
    typedef struct packed {
        logic [POSX_BITS-1:0] pos_x;
        logic [POSY_BITS-1:0] pos_y;
        logic                 last;
        logic [5:0]           count;
    } t_job;

endpackage

>>> hdl/wmf_if.sv
// Valid/ready stream interfaces used by the window median filter.
interface wmf_in_if #(parameter int PIXEL_BITS = 16);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel;
    logic                  frame_start;
    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface wmf_out_if #(parameter int PIXEL_BITS = 16);
    logic                  valid;
    logic                  ready;
    logic [15:0]           median_value;
    logic [10:0]           pos_x;
    logic [15:0]           pos_y;
    logic                  frame_last;
    modport source (output valid, output median_value, output pos_x, output pos_y,
                    output frame_last, input ready);
    modport sink   (input valid, input median_value, input pos_x, input pos_y,
                    input frame_last, output ready);
endinterface

interface wmf_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/wmf_cell.sv
// One cell of the odd-even transposition sort chain.
module wmf_cell #(
    parameter int W = 16
) (
    input  logic         i_clk,
    input  logic         i_load,
    input  logic [W-1:0] i_load_val,
    input  logic         i_phase_en,
    input  logic         i_upper,
    input  logic [W-1:0] i_left,
    input  logic [W-1:0] i_right,
    output logic [W-1:0] o_val
);
    logic [W-1:0] r_val;
    logic [W-1:0] n_val;

    // Pair with left or right neighbor; upper cell of a pair keeps the max
    always_comb begin
        n_val = r_val;
        if (i_load) begin
            n_val = i_load_val;
        end else if (i_phase_en) begin
            if (i_upper) begin
                n_val = (i_left > r_val) ? i_left : r_val;
            end else begin
                n_val = (i_right < r_val) ? i_right : r_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
endmodule

>>> hdl/wmf_sorter.sv
// Sort chain: loads the window, runs transposition passes, returns the median.
module wmf_sorter #(
    parameter int MAX_HALF   = 3,
    parameter int PIXEL_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [(2*MAX_HALF+1)**2*PIXEL_BITS-1:0] i_vals,
    input  logic [$clog2((2*MAX_HALF+1)**2+1)-1:0]  i_count,
    output logic                           o_busy,
    output logic                           o_done,
    input  logic                           i_take,
    output logic [PIXEL_BITS-1:0]          o_median
);
    import wmf_pkg::*;

    localparam int N  = (2*MAX_HALF+1)**2;
    localparam int CB = $clog2(N+1);

    t_state r_state, n_state;
    logic [CB-1:0] r_pass, n_pass;
    logic [CB-1:0] r_count;
    logic [PIXEL_BITS-1:0] w_val [N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pass  <= '0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
        end
        if (i_start) r_count <= i_count;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_pass  = r_pass;
        case (r_state)
            ST_IDLE: if (i_start) begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_state = ST_SORT;
                n_pass  = '0;
            end
            ST_SORT: begin
                n_pass = r_pass + 1'b1;
                if (r_pass + 1'b1 >= r_count) n_state = ST_DONE;
            end
            ST_DONE: if (i_take) begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_busy = (r_state != ST_IDLE);
        o_done = (r_state == ST_DONE);
    end

    // Chain of cells; unused tail loaded with max so it sorts to the top
    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            logic [PIXEL_BITS-1:0] w_l, w_r, w_ld;
            logic w_up, w_en;
            assign w_l  = (g > 0) ? w_val[(g > 0) ? g-1 : 0] : '0;
            assign w_r  = (g < N-1) ? w_val[(g < N-1) ? g+1 : g] : '0;
            assign w_ld = (CB'(g) < r_count) ? i_vals[g*PIXEL_BITS +: PIXEL_BITS] : '1;
            // Even pass pairs (0,1),(2,3)..; odd pass pairs (1,2),(3,4)..
            assign w_up = ((g % 2) == 1) ^ r_pass[0];
            assign w_en = (r_state == ST_SORT) &&
                          (w_up ? (g > 0) : (g < N-1));
            wmf_cell #(.W(PIXEL_BITS)) u_cell (
                .i_clk     (i_clk),
                .i_load    (r_state == ST_LOAD),
                .i_load_val(w_ld),
                .i_phase_en(w_en),
                .i_upper   (w_up),
                .i_left    (w_l),
                .i_right   (w_r),
                .o_val     (w_val[g])
            );
        end
    endgenerate

    assign o_median = w_val[r_count[CB-1:1]];
endmodule

>>> hdl/window_median_filter_top.sv
// Top level of the window median filter: line stores, window and sort chain.
// Each accepted pixel has its column gathered from the line store one slot per
// cycle and is written back to the store once the column is complete. When a
// pixel completes an interior window, the window is loaded into a chain of
// compare-exchange cells that runs n = (2*hx+1)*(2*hy+1) transposition passes
// (up to 49 by default). The result is held in the done state until the output
// takes it; input is held off while a gather or a sort is in flight. The store
// needs no clearing after reset.
module window_median_filter_top #(
    parameter int MAX_LINE   = wmf_pkg::MAX_LINE_DEF,
    parameter int MAX_HALF   = wmf_pkg::MAX_HALF_DEF,
    parameter int PIXEL_BITS = wmf_pkg::PIXEL_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wmf_in_if.sink    i_in,
    wmf_out_if.source o_out,
    wmf_cfg_if.sink   i_cfg
);
    import wmf_pkg::*;

    localparam int SLOTS = 2*MAX_HALF;
    localparam int SPAN  = 2*MAX_HALF+1;
    localparam int N     = SPAN*SPAN;
    localparam int CB    = $clog2(N+1);
    localparam int SB    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int AB    = $clog2(SLOTS*MAX_LINE);
    localparam int DB    = $clog2(SLOTS+1);

    // Configuration registers
    logic [LEN_BITS-1:0]  r_len;
    logic [CNT_BITS-1:0]  r_cnt;
    logic [HALF_BITS-1:0] r_hx, r_hy;

    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_BITS'(512);
            r_cnt <= CNT_BITS'(512);
            r_hx  <= HALF_BITS'(1);
            r_hy  <= HALF_BITS'(1);
        end else if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.index))
                REG_LINE_LENGTH: r_len <= i_cfg.data[LEN_BITS-1:0];
                REG_LINE_COUNT:  r_cnt <= i_cfg.data[CNT_BITS-1:0];
                REG_HALF_X:      r_hx  <= i_cfg.data[HALF_BITS-1:0];
                REG_HALF_Y:      r_hy  <= i_cfg.data[HALF_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Effective settings
    logic [LEN_BITS:0]  w_len;
    logic [CNT_BITS-1:0] w_cnt;
    logic [3:0] w_hx, w_hy;
    always_comb begin
        w_len = {1'b0, r_len};
        if (w_len < (LEN_BITS+1)'(1)) w_len = (LEN_BITS+1)'(1);
        if (w_len > (LEN_BITS+1)'(MAX_LINE)) w_len = (LEN_BITS+1)'(MAX_LINE);
        w_cnt = (r_cnt == 0) ? CNT_BITS'(1) : r_cnt;
        w_hx = (4'(r_hx) > 4'(MAX_HALF)) ? 4'(MAX_HALF) : 4'(r_hx);
        w_hy = (4'(r_hy) > 4'(MAX_HALF)) ? 4'(MAX_HALF) : 4'(r_hy);
    end

    // Front-end: gather column from line store one slot per cycle
    logic [CNT_BITS-1:0] r_x, r_y;
    logic [SB-1:0]       r_slot;
    logic [PIXEL_BITS-1:0] r_pix;
    logic                r_gather;
    logic [DB-1:0]       r_d;
    logic [PIXEL_BITS-1:0] r_col [SPAN];
    logic [PIXEL_BITS-1:0] r_win [SPAN][SPAN];
    logic [PIXEL_BITS-1:0] mem [SLOTS*MAX_LINE];
    logic [PIXEL_BITS-1:0] r_rd;
    logic                r_rd_v;
    logic [DB-1:0]       r_rd_d;
    logic                r_emit_pend;
    t_job                r_job;

    logic w_busy, w_done;
    logic [PIXEL_BITS-1:0] w_med;
    logic w_start;
    logic [N*PIXEL_BITS-1:0] w_vals;

    logic [CNT_BITS-1:0] w_x0, w_y0;
    assign w_x0 = i_in.frame_start ? '0 : r_x;
    assign w_y0 = i_in.frame_start ? '0 : r_y;

    logic w_acc;
    assign i_in.ready = !r_gather && !r_emit_pend && !w_busy;
    assign w_acc = i_in.valid && i_in.ready;

    // Slot arithmetic
    function automatic logic [SB-1:0] slot_back(input logic [SB-1:0] s,
                                                 input logic [DB-1:0] d);
        logic [SB+1:0] t;
        t = (SB+2)'(s) + (SB+2)'(SLOTS) - (SB+2)'(d);
        if (t >= (SB+2)'(SLOTS)) t = t - (SB+2)'(SLOTS);
        return t[SB-1:0];
    endfunction

    logic [SB-1:0] r_yslot;
    logic [SB-1:0] w_rd_slot;
    logic [CNT_BITS-1:0] r_gx;
    assign w_rd_slot = slot_back(r_slot, r_d);

    // Slot of current row tracked incrementally (y mod SLOTS)
    logic [SB-1:0] w_cur_slot;
    assign w_cur_slot = i_in.frame_start ? '0 : r_yslot;

    // Line store: new pixel goes in after the oldest line of its slot was read
    always_ff @(posedge i_clk) begin
        r_rd_v <= r_gather && (r_d <= DB'(SLOTS));
        if (r_gather && r_rd_v && (r_rd_d == DB'(SLOTS)) &&
            (r_gx < CNT_BITS'(MAX_LINE))) begin
            mem[AB'(r_slot)*AB'(MAX_LINE) + AB'(r_gx)] <= r_col[0];
        end
        if (r_gather && (r_d <= DB'(SLOTS))) begin
            r_rd   <= mem[AB'(w_rd_slot)*AB'(MAX_LINE) + AB'(r_gx)];
            r_rd_d <= r_d;
        end
    end

    // Sequencer of the front end
    logic w_inside, w_fires;
    always_comb begin
        w_inside = (w_x0 >= CNT_BITS'(2*w_hx)) && (w_x0 < CNT_BITS'(w_len)) &&
                   (w_y0 >= CNT_BITS'(2*w_hy)) && (w_y0 < w_cnt);
    end

    integer c, k;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0; r_y <= '0; r_yslot <= '0;
            r_gather <= 1'b0; r_emit_pend <= 1'b0; r_d <= '0;
        end else begin
            if (w_acc) begin
                r_gather <= 1'b1;
                r_d      <= DB'(1);
                r_slot   <= w_cur_slot;
                r_gx     <= w_x0;
                r_col[0] <= i_in.pixel;
                r_job.pos_x <= POSX_BITS'(w_x0 - CNT_BITS'(w_hx));
                r_job.pos_y <= POSY_BITS'(w_y0 - CNT_BITS'(w_hy));
                r_job.last  <= (w_x0 == CNT_BITS'(w_len - 1)) && (w_y0 == w_cnt - 1'b1);
                r_job.count <= 6'((2*w_hx+1)*(2*w_hy+1));
                r_emit_pend <= w_inside;
                if (w_x0 + 1'b1 >= CNT_BITS'(w_len)) begin
                    r_x <= '0;
                    if ({1'b0, w_y0} + 1'b1 >= {1'b0, w_cnt}) begin
                        r_y <= '0; r_yslot <= '0;
                    end else begin
                        r_y <= w_y0 + 1'b1;
                        r_yslot <= (w_cur_slot == SB'(SLOTS-1)) ? '0 : w_cur_slot + 1'b1;
                    end
                end else begin
                    r_x <= w_x0 + 1'b1;
                    r_yslot <= w_cur_slot;
                    if (i_in.frame_start) r_y <= '0;
                end
            end
            if (r_gather) begin
                if (r_d <= DB'(SLOTS)) r_d <= r_d + 1'b1;
                if (r_rd_v) begin
                    r_col[r_rd_d] <= (r_gx < CNT_BITS'(MAX_LINE)) ? r_rd : '0;
                end
                if (r_rd_v && (r_rd_d == DB'(SLOTS))) begin
                    r_gather <= 1'b0;
                    // shift the window by one column
                    for (c = 0; c < SPAN-1; c++)
                        for (k = 0; k < SPAN; k++)
                            r_win[c][k] <= r_win[c+1][k];
                    for (k = 0; k < SPAN-1; k++) r_win[SPAN-1][k] <= r_col[k];
                    r_win[SPAN-1][SPAN-1] <= (r_gx < CNT_BITS'(MAX_LINE)) ? r_rd : '0;
                end
            end
            if (w_start) r_emit_pend <= 1'b0;
        end
    end

    assign w_start = r_emit_pend && !r_gather && !w_busy;

    // Pack the active window: rightmost 2*hx+1 columns left to right, rows from the newest line up
    always_comb begin
        int n;
        n = 0;
        w_vals = '0;
        for (int cc = 0; cc < SPAN; cc++)
            for (int kk = 0; kk < SPAN; kk++)
                if ((cc >= SPAN-1-2*w_hx) && (kk <= 2*w_hy)) begin
                    w_vals[n*PIXEL_BITS +: PIXEL_BITS] = r_win[cc][kk];
                    n = n + 1;
                end
    end

    t_job r_out_job;
    always_ff @(posedge i_clk) if (w_start) r_out_job <= r_job;

    wmf_sorter #(.MAX_HALF(MAX_HALF), .PIXEL_BITS(PIXEL_BITS)) u_sorter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_vals  (w_vals),
        .i_count (CB'(r_job.count)),
        .o_busy  (w_busy),
        .o_done  (w_done),
        .i_take  (o_out.ready),
        .o_median(w_med)
    );

    assign o_out.valid        = w_done;
    assign o_out.median_value = MED_BITS'(w_med);
    assign o_out.pos_x        = r_out_job.pos_x;
    assign o_out.pos_y        = r_out_job.pos_y;
    assign o_out.frame_last   = r_out_job.last;
endmodule
